// File: hw/rtl/sts_pkg.sv
// sts_pkg: constants, types and helpers for the speaker turn segmenter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;
  localparam int SPEAKERS   = 4;
  localparam int FRAME_BITS = 20;
  localparam int PROB_BITS  = 16;
  localparam int SPK_BITS   = 2;
  localparam int CNT_BITS   = FRAME_BITS + 1;
  localparam int SUM_BITS   = PROB_BITS + FRAME_BITS;
  localparam int SAMPLE_BITS = 31;
  localparam int HOP_SAMPLES = 1280;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 21;

  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LEN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_LEN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_CNT = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_EMIT_OPEN = 3'd4;

  // one closed run as seen by the merge stage
  typedef struct packed {
    logic                  hit;
    logic [CNT_BITS-1:0]   start;
    logic [CNT_BITS-1:0]   end_f;
    logic [SUM_BITS-1:0]   sum;
  } lane_close_t;

  typedef struct packed {
    logic [SPK_BITS-1:0]    speaker;
    logic [SAMPLE_BITS-1:0] begin_sample;
    logic [SAMPLE_BITS-1:0] end_sample;
    logic [PROB_BITS-1:0]   confidence;
    logic                   last_turn;
  } turn_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIV, ST_MUL, ST_OUT
  } seq_state_t;
endpackage
`default_nettype wire

// File: hw/rtl/sts_if.sv
// sts_if: valid/ready channel interfaces for frames and turns
// depends on sts_pkg
`timescale 1ns / 1ps
`default_nettype none
interface sts_frame_if import sts_pkg::*; ;
  logic valid;
  logic ready;
  logic [PROB_BITS-1:0] prob_spk0;
  logic [PROB_BITS-1:0] prob_spk1;
  logic [PROB_BITS-1:0] prob_spk2;
  logic [PROB_BITS-1:0] prob_spk3;
  modport source(output valid, prob_spk0, prob_spk1, prob_spk2, prob_spk3, input ready);
  modport sink(input valid, prob_spk0, prob_spk1, prob_spk2, prob_spk3, output ready);
endinterface

interface sts_turn_if import sts_pkg::*; ;
  logic valid;
  logic ready;
  logic [SPK_BITS-1:0]    speaker;
  logic [SAMPLE_BITS-1:0] begin_sample;
  logic [SAMPLE_BITS-1:0] end_sample;
  logic [PROB_BITS-1:0]   confidence;
  logic                   last_turn;
  modport source(output valid, speaker, begin_sample, end_sample, confidence, last_turn,
                 input ready);
  modport sink(input valid, speaker, begin_sample, end_sample, confidence, last_turn,
               output ready);
endinterface
`default_nettype wire

// File: hw/rtl/speaker_turn_segmenter.sv
// speaker_turn_segmenter: top level, lanes, configuration and merge
// depends on sts_pkg, sts_if, sts_lane, sts_merge
`timescale 1ns / 1ps
`default_nettype none
// Use: frames enter on the in_ channel, one probability per speaker; closed
// turns leave on the out_ channel, one beat per turn, last_turn on the final
// beat that a frame caused. Frames that close nothing produce no beat.
// Four lanes threshold and track runs on each frame beat; the merge stage then
// walks the up to eight closed runs in order (ended runs by speaker, then
// runs closed at the final frame by speaker), pads and filters each, and
// divides the run sum by its length in a bit-serial divider.
// The closed runs are registered with the frame beat and reach the merge
// stage in the cycle after it; each emitted turn then takes a scan, one
// divider step per quotient bit, and a scaling and output load step.
// Runs that the length filter drops are masked when the merge stage loads
// and are never scanned. A frame is taken only when the merge stage and its
// output register are empty and no load is pending.
// A stalled receiver holds the output register; the merge stage waits.
// Reset (rst_n low, synchronous) loads the register defaults, clears all
// open runs and the frame counter; run starts and sums need no clearing.
// Configuration writes go through cfg_we/cfg_index/cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it.
module speaker_turn_segmenter import sts_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  sts_frame_if.sink                     in_ch,
  sts_turn_if.source                    out_ch,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
  logic [PROB_BITS-1:0] threshold_r;
  logic [CNT_BITS-1:0]  min_len_r, pad_len_r, frame_cnt_r;
  logic                 emit_open_r;
  logic [CNT_BITS-1:0]  frame_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= PROB_BITS'(32768);
      min_len_r   <= '0;
      pad_len_r   <= '0;
      frame_cnt_r <= CNT_BITS'(1 << FRAME_BITS);
      emit_open_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_r <= cfg_data[PROB_BITS-1:0];
        REG_MIN_LEN:   min_len_r   <= cfg_data[CNT_BITS-1:0];
        REG_PAD_LEN:   pad_len_r   <= cfg_data[CNT_BITS-1:0];
        REG_FRAME_CNT: frame_cnt_r <= cfg_data[CNT_BITS-1:0];
        REG_EMIT_OPEN: emit_open_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective frame count: zero acts as one, above 2^FRAME_BITS clamps
  logic [CNT_BITS-1:0] count;
  always_comb begin
    count = frame_cnt_r;
    if (count == '0) count = CNT_BITS'(1);
    if (count > CNT_BITS'(1 << FRAME_BITS)) count = CNT_BITS'(1 << FRAME_BITS);
  end

  logic busy, step, last;
  logic load_r;
  logic [CNT_BITS:0] f_inc;
  assign f_inc = {1'b0, frame_r} + (CNT_BITS+1)'(1);
  assign last = f_inc >= {1'b0, count};
  assign in_ch.ready = !busy && !load_r;
  assign step = in_ch.valid && in_ch.ready;

  lane_close_t [2*SPEAKERS-1:0] closes, closes_r;
  logic [PROB_BITS-1:0] probs [SPEAKERS];
  assign probs[0] = in_ch.prob_spk0;
  assign probs[1] = in_ch.prob_spk1;
  assign probs[2] = in_ch.prob_spk2;
  assign probs[3] = in_ch.prob_spk3;

  for (genvar s = 0; s < SPEAKERS; s++) begin : g_lane
    sts_lane u_lane (
      .clk(clk), .rst_n(rst_n), .step(step), .prob(probs[s]),
      .threshold(threshold_r), .frame(frame_r), .last(last),
      .emit_open(emit_open_r), .end_close(closes[s]),
      .fin_close(closes[SPEAKERS + s])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
      load_r  <= 1'b0;
    end else begin
      load_r <= step;
      if (step) frame_r <= last ? '0 : f_inc[CNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (step) closes_r <= closes;
  end

  turn_t turn;
  sts_merge u_merge (
    .clk(clk), .rst_n(rst_n), .load(load_r), .closes(closes_r),
    .count(count), .min_len(min_len_r), .pad_len(pad_len_r),
    .busy(busy), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_turn(turn)
  );
  assign out_ch.speaker      = turn.speaker;
  assign out_ch.begin_sample = turn.begin_sample;
  assign out_ch.end_sample   = turn.end_sample;
  assign out_ch.confidence   = turn.confidence;
  assign out_ch.last_turn    = turn.last_turn;

  // no frame accepted while the merge stage holds work
  a_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("frame accepted while busy");
  // frame counter wraps to zero after the last frame of the effective count
  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(step) && $past(last) |-> frame_r == '0) else $error("frame wrap");
  // load follows every accepted frame
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> load_r) else $error("missing load");
endmodule
`default_nettype wire

// File: hw/rtl/sts_lane.sv
// sts_lane: per-speaker threshold and run tracker
// depends on sts_pkg
`timescale 1ns / 1ps
`default_nettype none
module sts_lane import sts_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [PROB_BITS-1:0]  prob,
  input  wire logic [PROB_BITS-1:0]  threshold,
  input  wire logic [CNT_BITS-1:0]   frame,
  input  wire logic                  last,
  input  wire logic                  emit_open,
  output lane_close_t                end_close,
  output lane_close_t                fin_close
);
  logic                  open_r;
  logic [FRAME_BITS-1:0] start_r;
  logic [SUM_BITS-1:0]   sum_r;
  logic                  active;
  logic                  open_after;

  assign active = prob >= threshold;
  assign open_after = active;

  always_comb begin
    end_close.hit   = open_r && !active;
    end_close.start = {1'b0, start_r};
    end_close.end_f = frame;
    end_close.sum   = sum_r;
    fin_close.hit   = last && emit_open && active;
    fin_close.start = open_r ? {1'b0, start_r} : frame;
    fin_close.end_f = frame + CNT_BITS'(1);
    fin_close.sum   = open_r ? sum_r + SUM_BITS'(prob) : SUM_BITS'(prob);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (step) begin
      open_r <= open_after && !last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && active) begin
      if (!open_r) begin
        start_r <= frame[FRAME_BITS-1:0];
        sum_r   <= SUM_BITS'(prob);
      end else begin
        sum_r <= sum_r + SUM_BITS'(prob);
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/sts_merge.sv
// sts_merge: pads, filters and scales closed runs one at a time, serial mean divider
// depends on sts_pkg
`timescale 1ns / 1ps
`default_nettype none
module sts_merge import sts_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire lane_close_t [2*SPEAKERS-1:0] closes,
  input  wire logic [CNT_BITS-1:0]      count,
  input  wire logic [CNT_BITS-1:0]      min_len,
  input  wire logic [CNT_BITS-1:0]      pad_len,
  output logic                          busy,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output turn_t                         out_turn
);
  localparam int SLOTS = 2 * SPEAKERS;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int DIV_BITS = $clog2(SUM_BITS + 1);
  localparam int MUL_BITS = CNT_BITS + 11;

  seq_state_t state_r, state_nxt;
  lane_close_t [SLOTS-1:0] slot_r;
  logic [SLOTS-1:0] pend_r, pend_nxt;
  logic [SLOT_BITS-1:0] sel;
  logic found;
  logic [SLOTS-1:0] rest;
  logic [SLOTS-1:0] load_mask;

  logic [SPK_BITS-1:0] spk_r;
  logic [CNT_BITS-1:0] pstart_r, pend_f_r, len_r;
  logic [SUM_BITS-1:0] quo_r, rem_r;
  logic [DIV_BITS-1:0] dcnt_r;
  logic                lastm_r;
  turn_t               turn_r;
  logic                valid_r;

  // pad and clamp for the chosen slot
  logic [CNT_BITS-1:0] c_start, c_end, c_limit, c_pstart, c_len;
  logic [CNT_BITS:0]   c_pend_w;
  logic [CNT_BITS-1:0] c_pend;

  // length filter for one run after padding and clamping
  function automatic logic slot_keep(input lane_close_t c, input logic [CNT_BITS-1:0] cnt,
                                     input logic [CNT_BITS-1:0] pad,
                                     input logic [CNT_BITS-1:0] mlen);
    logic [CNT_BITS-1:0] lim, ps, pe;
    logic [CNT_BITS:0]   pw;
    lim = (cnt > c.end_f) ? cnt : c.end_f;
    ps = (c.start > pad) ? c.start - pad : '0;
    pw = {1'b0, c.end_f} + {1'b0, pad};
    pe = (pw > {1'b0, lim}) ? lim : pw[CNT_BITS-1:0];
    return (pe - ps) >= mlen;
  endfunction

  // only runs that survive the filter are queued, so the last queued one is the last turn
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      load_mask[i] = closes[i].hit && slot_keep(closes[i], count, pad_len, min_len);
    end
  end

  always_comb begin
    found = 1'b0;
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        found = 1'b1;
        sel = SLOT_BITS'(i);
      end
    end
    rest = pend_r;
    rest[sel] = 1'b0;
    c_start = slot_r[sel].start;
    c_end = slot_r[sel].end_f;
    c_limit = (count > c_end) ? count : c_end;
    c_pstart = (c_start > pad_len) ? c_start - pad_len : '0;
    c_pend_w = {1'b0, c_end} + {1'b0, pad_len};
    c_pend = (c_pend_w > {1'b0, c_limit}) ? c_limit : c_pend_w[CNT_BITS-1:0];
    c_len = (c_end > c_start) ? c_end - c_start : CNT_BITS'(1);
  end

  logic [SUM_BITS:0] rem_sh;
  logic [SUM_BITS:0] rem_sub;
  always_comb begin
    rem_sh = {rem_r, quo_r[SUM_BITS-1]};
    rem_sub = rem_sh - {{(SUM_BITS-CNT_BITS+1){1'b0}}, len_r};
  end

  logic [MUL_BITS-1:0] ms, me;
  always_comb begin
    ms = MUL_BITS'(pstart_r) * MUL_BITS'(HOP_SAMPLES);
    me = MUL_BITS'(pend_f_r) * MUL_BITS'(HOP_SAMPLES);
  end

  assign busy = (state_r != ST_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign out_turn = turn_r;

  always_comb begin
    state_nxt = state_r;
    pend_nxt = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_SCAN;
          pend_nxt = load_mask;
        end
      end
      ST_SCAN: begin
        if (!found) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
          pend_nxt = rest;
        end
      end
      ST_DIV: if (dcnt_r == DIV_BITS'(SUM_BITS - 1)) state_nxt = ST_MUL;
      ST_MUL: if (!valid_r || out_ready) state_nxt = ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (state_r == ST_MUL && (!valid_r || out_ready)) valid_r <= 1'b1;
      else if (out_ready) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && load) slot_r <= closes;
    if (state_r == ST_SCAN && found) begin
      spk_r    <= SPK_BITS'(sel[SPK_BITS-1:0]);
      pstart_r <= c_pstart;
      pend_f_r <= c_pend;
      len_r    <= c_len;
      quo_r    <= slot_r[sel].sum;
      rem_r    <= '0;
      dcnt_r   <= '0;
      // every queued slot is emitted, so last is set once the queue is empty
      lastm_r  <= 1'b1;
    end
    if (state_r == ST_DIV) begin
      dcnt_r <= dcnt_r + DIV_BITS'(1);
      if (!rem_sub[SUM_BITS]) begin
        rem_r <= rem_sub[SUM_BITS-1:0];
        quo_r <= {quo_r[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[SUM_BITS-1:0];
        quo_r <= {quo_r[SUM_BITS-2:0], 1'b0};
      end
    end
    if (state_r == ST_MUL && (!valid_r || out_ready)) begin
      turn_r.speaker      <= spk_r;
      turn_r.begin_sample <= ms[SAMPLE_BITS-1:0];
      turn_r.end_sample   <= me[SAMPLE_BITS-1:0];
      turn_r.confidence   <= quo_r[PROB_BITS-1:0];
      turn_r.last_turn    <= lastm_r && (pend_r == '0);
    end
  end
endmodule
`default_nettype wire
